FILE: design/mttk_pkg.sv
// ----------------------------------------------------------------------------
// mttk_pkg
// Shared types, codes and constants of the trusted time keeper.
// ----------------------------------------------------------------------------
package mttk_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_RESTORE = 2'd1,
    CMD_OBSERVE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_BACKWARD    = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_UNAVAILABLE = 3'd4
  } status_e;

  // Time source codes
  localparam logic [2:0] OBS_SRC_SNTP   = 3'd1;
  localparam logic [2:0] OBS_SRC_CORROB = 3'd2;
  localparam logic [1:0] SRC_UNTRUSTED  = 2'd0;
  localparam logic [1:0] SRC_CHECKPOINT = 2'd3;

  // Accepted UTC window, milliseconds
  localparam logic signed [63:0] WIN_LOW_MS  = 64'sd1704067200000;
  localparam logic signed [63:0] WIN_HIGH_MS = 64'sd4102444800000;

  localparam logic [31:0] DEF_BACKSTEP_MS = 32'd300000;

  // Divide-by-1000 of the monotonic counter, 16 bits per chunk
  localparam int unsigned DIVISOR     = 1000;
  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned NUM_CHUNKS  = 4;
  localparam int unsigned MONO_W      = 63;
  localparam int unsigned MONO_PAD_W  = CHUNK_W * NUM_CHUNKS;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned DVD_W       = REM_W + CHUNK_W;
  localparam int unsigned RECIP_SHIFT = DVD_W + REM_W;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned PROD_W      = DVD_W + RECIP_W;
  // ceil(2^36 / 1000), exact for any 26-bit dividend
  localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
  localparam int unsigned QUO_W       = 54;

  // Signed width for anchor arithmetic with headroom
  localparam int unsigned WIDE_W = 68;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         time_source;
    logic signed [63:0] wall_utc_ms;
    logic               checkpoint_found;
    logic [62:0]        mono_count_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [62:0] now_utc_ms;
    logic [1:0]  current_source;
    logic        is_trusted;
    logic        persist_request;
    logic [62:0] persist_utc_ms;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_e               cmd;
    logic               arg_ok;
    logic [1:0]         src;
    logic signed [63:0] wall;
    wide_t              x;      // wall - mono/1000 (init: -mono/1000)
    logic [QUO_W-1:0]   qm;     // floor(mono / 1000)
    logic [REM_W-1:0]   rm;     // mono % 1000
  } fe_item_t;

endpackage

FILE: design/mttk_front.sv
// ----------------------------------------------------------------------------
// mttk_front
// Accepts commands, checks arguments and splits the monotonic counter into
// quotient and remainder by 1000 in a pipelined long division.
// ----------------------------------------------------------------------------
module mttk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mttk_pkg::in_item_t  in_item_i,
  output logic                fe_valid_o,
  input  logic                fe_ready_i,
  output mttk_pkg::fe_item_t  fe_item_o
);
  import mttk_pkg::*;

  localparam int unsigned NumStg = 2 * NUM_CHUNKS;

  typedef struct packed {
    cmd_e                  cmd;
    logic                  arg_ok;
    logic [1:0]            src;
    logic signed [63:0]    wall;
    logic [MONO_PAD_W-1:0] mono;
    logic [REM_W-1:0]      rem;
    logic [MONO_PAD_W-1:0] quo;
    logic [DVD_W-1:0]      dvd;
    logic [PROD_W-1:0]     prod;
  } fp_t;

  fp_t               in_fp;
  fp_t               stg_q [NumStg];
  fp_t               stg_d [NumStg];
  logic [NumStg-1:0] vld_q;
  logic              en;
  logic              in_win;
  fp_t               last;

  assign en         = !(vld_q[NumStg-1] && !fe_ready_i);
  assign in_stall_o = !en;

  assign in_win = (in_item_i.wall_utc_ms >= WIN_LOW_MS) &&
                  (in_item_i.wall_utc_ms < WIN_HIGH_MS);

  always_comb begin
    in_fp        = '0;
    in_fp.cmd    = cmd_e'(in_item_i.command);
    in_fp.src    = in_item_i.time_source[1:0];
    in_fp.wall   = in_item_i.wall_utc_ms;
    in_fp.mono   = MONO_PAD_W'(in_item_i.mono_count_us);
    case (cmd_e'(in_item_i.command))
      CMD_RESTORE: in_fp.arg_ok = in_item_i.checkpoint_found && in_win;
      CMD_OBSERVE: in_fp.arg_ok = in_win &&
                                  ((in_item_i.time_source == OBS_SRC_SNTP) ||
                                   (in_item_i.time_source == OBS_SRC_CORROB));
      default:     in_fp.arg_ok = 1'b1;
    endcase
  end

  // Even stages multiply by the reciprocal, odd stages form quotient digit
  // and remainder. Highest chunk first.
  for (genvar s = 0; s < NumStg; s++) begin : g_stg
    localparam int unsigned Ck = NUM_CHUNKS - 1 - s / 2;
    fp_t prv;

    if (s == 0) begin : g_first
      assign prv = in_fp;
    end else begin : g_next
      assign prv = stg_q[s-1];
    end

    if (s % 2 == 0) begin : g_mul
      always_comb begin
        stg_d[s]      = prv;
        stg_d[s].dvd  = {prv.rem, prv.mono[Ck*CHUNK_W +: CHUNK_W]};
        stg_d[s].prod = PROD_W'(stg_d[s].dvd) * PROD_W'(DIV_RECIP);
      end
    end else begin : g_rem
      always_comb begin
        logic [CHUNK_W-1:0] qt;
        logic [DVD_W-1:0]   qk;
        qt           = prv.prod[RECIP_SHIFT +: CHUNK_W];
        qk           = DVD_W'(qt) * DVD_W'(DIVISOR);
        stg_d[s]     = prv;
        stg_d[s].rem = REM_W'(prv.dvd - qk);
        stg_d[s].quo = {prv.quo[MONO_PAD_W-CHUNK_W-1:0], qt};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumStg; i++) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  assign last = stg_q[NumStg-1];

  always_comb begin
    fe_item_o        = '0;
    fe_item_o.cmd    = last.cmd;
    fe_item_o.arg_ok = last.arg_ok;
    fe_item_o.src    = last.src;
    fe_item_o.wall   = last.wall;
    fe_item_o.qm     = last.quo[QUO_W-1:0];
    fe_item_o.rm     = last.rem;
    // init anchors wall time zero to the current counter
    fe_item_o.x      = ((last.cmd == CMD_INIT) ? wide_t'(0) : wide_t'(last.wall)) -
                       wide_t'(last.quo[QUO_W-1:0]);
  end

  assign fe_valid_o = vld_q[NumStg-1];

endmodule

FILE: design/mttk_queue.sv
// ----------------------------------------------------------------------------
// mttk_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module mttk_queue #(
  parameter int unsigned Depth = mttk_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  mttk_pkg::fe_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output mttk_pkg::fe_item_t pop_item_o
);
  import mttk_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fe_item_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: design/mttk_back.sv
// ----------------------------------------------------------------------------
// mttk_back
// Holds the time anchor, executes one classified command per cycle unless the
// held output is stalled, and registers the result.
// ----------------------------------------------------------------------------
module mttk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                it_valid_i,
  output logic                it_pop_o,
  input  mttk_pkg::fe_item_t  it_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mttk_pkg::out_item_t out_item_o
);
  import mttk_pkg::*;

  // Anchor kept as base = anchor_utc - anchor_mono/1000 (floor) plus the
  // split counter; bm = base - max_backward_step.
  logic               trusted_q, trusted_d;
  logic [1:0]         source_q, source_d;
  wide_t              base_q, base_d;
  wide_t              bm_q, bm_d;
  logic [QUO_W-1:0]   qa_q, qa_d;
  logic [REM_W-1:0]   ra_q, ra_d;
  logic signed [63:0] last_q, last_d;
  logic [31:0]        max_q, max_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, res;

  logic  fire;
  logic  qm_lt, qm_gt, r_neg, r_pos;
  logic  corr_p1, corr_m1, mono_lt;
  wide_t corr, qm_w, proj, e0, diff;
  logic  p_below_last, back_rej;

  assign cfg_ready_o = 1'b1;
  assign fire        = it_valid_i && (!out_valid_q || !out_stall_i);
  assign it_pop_o    = fire;

  assign qm_lt   = it_i.qm < qa_q;
  assign qm_gt   = it_i.qm > qa_q;
  assign r_neg   = it_i.rm < ra_q;
  assign r_pos   = it_i.rm > ra_q;
  // truncation toward zero of the elapsed ms from the floor split
  assign corr_p1 = qm_lt && r_pos;
  assign corr_m1 = qm_gt && r_neg;
  assign mono_lt = qm_lt || ((it_i.qm == qa_q) && r_neg);
  assign corr    = corr_p1 ? wide_t'(1) : (corr_m1 ? -wide_t'(1) : wide_t'(0));
  assign qm_w    = wide_t'(it_i.qm);

  assign proj = base_q + qm_w + corr;
  assign e0   = base_q + qm_w - wide_t'(last_q);
  assign diff = it_i.x - bm_q;

  assign p_below_last = corr_p1 ? (e0 < -1) : (corr_m1 ? (e0 <= 0) : (e0 < 0));
  assign back_rej     = trusted_q &&
                        (corr_p1 ? (diff <= 0) : (corr_m1 ? (diff < -1) : (diff < 0)));

  always_comb begin
    trusted_d = trusted_q;
    source_d  = source_q;
    base_d    = base_q;
    qa_d      = qa_q;
    ra_d      = ra_q;
    last_d    = last_q;
    max_d     = max_q;
    res       = '0;

    if (cfg_valid_i) begin
      max_d = cfg_data_i;
    end

    if (fire) begin
      res.status = ST_OK;
      case (it_i.cmd)
        CMD_INIT: begin
          trusted_d = 1'b0;
          source_d  = SRC_UNTRUSTED;
          base_d    = it_i.x;
          qa_d      = it_i.qm;
          ra_d      = it_i.rm;
          last_d    = '0;
          max_d     = DEF_BACKSTEP_MS;
        end
        CMD_RESTORE: begin
          if (!it_i.arg_ok) begin
            res.status = ST_NOT_FOUND;
          end else begin
            trusted_d = 1'b1;
            source_d  = SRC_CHECKPOINT;
            base_d    = it_i.x;
            qa_d      = it_i.qm;
            ra_d      = it_i.rm;
            last_d    = it_i.wall;
          end
        end
        CMD_OBSERVE: begin
          if (!it_i.arg_ok) begin
            res.status = ST_INVALID;
          end else if (back_rej) begin
            res.status = ST_BACKWARD;
          end else begin
            trusted_d = 1'b1;
            source_d  = it_i.src;
            base_d    = it_i.x;
            qa_d      = it_i.qm;
            ra_d      = it_i.rm;
            last_d    = (it_i.wall > last_q) ? it_i.wall : last_q;
            res.persist_request = 1'b1;
            res.persist_utc_ms  = last_d[62:0];
          end
        end
        CMD_QUERY: begin
          if (!trusted_q || mono_lt) begin
            res.status = ST_UNAVAILABLE;
          end else begin
            last_d         = p_below_last ? last_q : proj[63:0];
            res.now_utc_ms = last_d[62:0];
          end
        end
        default: begin
          res.status = ST_INVALID;
        end
      endcase
      res.current_source = source_d;
      res.is_trusted     = trusted_d;
    end

    bm_d = base_d - wide_t'(max_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trusted_q   <= 1'b0;
      source_q    <= SRC_UNTRUSTED;
      base_q      <= '0;
      bm_q        <= -wide_t'(DEF_BACKSTEP_MS);
      qa_q        <= '0;
      ra_q        <= '0;
      last_q      <= '0;
      max_q       <= DEF_BACKSTEP_MS;
      out_valid_q <= 1'b0;
    end else begin
      trusted_q   <= trusted_d;
      source_q    <= source_d;
      base_q      <= base_d;
      bm_q        <= bm_d;
      qa_q        <= qa_d;
      ra_q        <= ra_d;
      last_q      <= last_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: design/monotonic_trusted_time_keeper.sv
// ----------------------------------------------------------------------------
// monotonic_trusted_time_keeper
// Wall-clock anchor tied to a monotonic microsecond counter: init, restore,
// observe and query commands, one result per command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------
//  in      | input     | in_valid / in_stall   | in_item_i  (in_item_t)
//  out     | output    | out_valid / out_stall | out_item_o (out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data_i (max backward ms)
//
// One command per cycle sustained while the output is not stalled. A command
// passes the 8 stages of the divide-by-1000 pipeline in the front, the queue,
// then the back unit that updates the anchor and loads the output register.
// Reset puts the anchor in the untrusted state; no clearing pass.
// An output stall fills the output register, then the queue; in_stall_o rises
// once the last front stage holds a command that the full queue cannot take.
// ----------------------------------------------------------------------------
module monotonic_trusted_time_keeper #(
  parameter int unsigned QueueDepth = mttk_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mttk_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mttk_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import mttk_pkg::*;

  logic     fe_valid, fe_ready;
  fe_item_t fe_item;
  logic     q_valid, q_pop;
  fe_item_t q_item;

  mttk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .fe_valid_o (fe_valid),
    .fe_ready_i (fe_ready),
    .fe_item_o  (fe_item)
  );

  mttk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_item_i  (fe_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  mttk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .it_valid_i  (q_valid),
    .it_pop_o    (q_pop),
    .it_i        (q_item),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
